>>> rtl/core/stq_pkg.sv
// Shared widths, operation codes and error codes for the slot table.
`default_nettype none

package stq_pkg;

  localparam int MODE_W     = 2;
  localparam int SLOT_IDX_W = 10;
  localparam int HANDLE_W   = 32;
  localparam int COUNT_W    = 11;
  localparam int ERR_W      = 2;

  localparam int SLOT_COUNT_DEF  = 1024;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OCCUPIED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL     = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/stq_if.sv
// Request and response channel interfaces of the slot table.
`default_nettype none

interface stq_req_if;
  logic                            valid;
  logic                            ready;
  logic [stq_pkg::MODE_W-1:0]      mode;
  logic [stq_pkg::SLOT_IDX_W-1:0]  slot_index;
  logic [stq_pkg::HANDLE_W-1:0]    member_handle;

  modport source (output valid, mode, slot_index, member_handle, input ready);
  modport sink   (input valid, mode, slot_index, member_handle, output ready);
endinterface

interface stq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [stq_pkg::SLOT_IDX_W-1:0]  result_index;
  logic [stq_pkg::HANDLE_W-1:0]    result_handle;
  logic [stq_pkg::COUNT_W-1:0]     live_count;
  logic [stq_pkg::ERR_W-1:0]       error_code;

  modport source (output valid, result_index, result_handle, live_count, error_code,
                  input ready);
  modport sink   (input valid, result_index, result_handle, live_count, error_code,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/slot_table_with_free_index_queue.sv
// Slot table top level: one item in flight; an accepted word passes S_READ1 and then S_OUT
// into the response register, with S_READ2 between them for an add that reuses a freed
// index (queue read, then slot read). A new word is accepted only after the last one has
// left S_OUT, which waits while the response register is stalled.
// Synchronous reset empties the queue and clears the issue and live counters; memory
// contents are not cleared, since no entry is read before it is written.
`default_nettype none

module slot_table_with_free_index_queue #(
  parameter int SLOT_COUNT  = stq_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = stq_pkg::HANDLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  stq_req_if.sink   req,
  stq_rsp_if.source rsp
);

  import stq_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int KW = (CW > SLOT_IDX_W) ? CW : SLOT_IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ1 = 2'd1;
  localparam logic [1:0] S_READ2 = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  // Control state.
  logic [1:0]    state, state_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] fresh, fresh_next;
  logic [CW-1:0] occ, occ_next;
  logic          out_valid, out_valid_next;

  // Item and result holding registers.
  logic [MODE_W-1:0]     mode_r, mode_next;
  logic [SLOT_IDX_W-1:0] sidx_r, sidx_next;
  logic [HANDLE_BITS-1:0] member_r, member_next;
  logic [IW-1:0]         add_idx, add_idx_next;
  logic [SLOT_IDX_W-1:0] res_index, res_index_next;
  logic [HANDLE_W-1:0]   res_handle, res_handle_next;
  logic [ERR_W-1:0]      res_err, res_err_next;
  logic [SLOT_IDX_W-1:0] out_index, out_index_next;
  logic [HANDLE_W-1:0]   out_handle, out_handle_next;
  logic [COUNT_W-1:0]    out_count, out_count_next;
  logic [ERR_W-1:0]      out_err, out_err_next;

  // Memory ports.
  logic                   slot_we;
  logic [IW-1:0]          slot_waddr, slot_raddr;
  logic [HANDLE_BITS-1:0] slot_wdata, slot_rdata;
  logic                   q_we;
  logic [IW-1:0]          q_rdata;

  logic sidx_ok;
  logic slot_full;

  stq_ram #(.DEPTH(SLOT_COUNT), .WIDTH(HANDLE_BITS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  stq_ram #(.DEPTH(SLOT_COUNT), .WIDTH(IW)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (IW'(sidx_r)),
    .raddr (head),
    .rdata (q_rdata)
  );

  // The slot read is issued at acceptance for remove and get; for a reusing add the
  // second read goes to the index just fetched from the queue.
  assign slot_raddr = (state == S_READ1) ? q_rdata : IW'(req.slot_index);

  assign sidx_ok   = KW'(sidx_r) < KW'(fresh);
  assign slot_full = |slot_rdata;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.result_index  = out_index;
  assign rsp.result_handle = out_handle;
  assign rsp.live_count    = out_count;
  assign rsp.error_code    = out_err;

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    fresh_next      = fresh;
    occ_next        = occ;
    out_valid_next  = out_valid && !rsp.ready;
    mode_next       = mode_r;
    sidx_next       = sidx_r;
    member_next     = member_r;
    add_idx_next    = add_idx;
    res_index_next  = res_index;
    res_handle_next = res_handle;
    res_err_next    = res_err;
    out_index_next  = out_index;
    out_handle_next = out_handle;
    out_count_next  = out_count;
    out_err_next    = out_err;
    slot_we         = 1'b0;
    slot_waddr      = IW'(sidx_r);
    slot_wdata      = '0;
    q_we            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          mode_next   = req.mode;
          sidx_next   = req.slot_index;
          member_next = HANDLE_BITS'(req.member_handle);
          state_next  = S_READ1;
        end
      end

      S_READ1: begin
        res_index_next  = sidx_r;
        res_handle_next = '0;
        res_err_next    = ERR_OK;
        state_next      = S_OUT;
        unique case (mode_r)
          MODE_ADD: begin
            if (fill != '0) begin
              add_idx_next = q_rdata;
              state_next   = S_READ2;
            end else if (fresh < CW'(SLOT_COUNT)) begin
              slot_we        = 1'b1;
              slot_waddr     = fresh[IW-1:0];
              slot_wdata     = member_r;
              fresh_next     = fresh + 1'b1;
              if (occ < CW'(SLOT_COUNT)) begin
                occ_next = occ + 1'b1;
              end
              res_index_next = SLOT_IDX_W'(fresh);
            end else begin
              res_index_next = '0;
              res_err_next   = ERR_FULL;
            end
          end
          MODE_REMOVE, MODE_GET: begin
            if (!sidx_ok) begin
              res_err_next = ERR_RANGE;
            end else begin
              res_handle_next = HANDLE_W'(slot_rdata);
              if (mode_r == MODE_REMOVE && slot_full) begin
                slot_we = 1'b1;
                if (fill < CW'(SLOT_COUNT)) begin
                  q_we      = 1'b1;
                  tail_next = (tail == IW'(SLOT_COUNT - 1)) ? '0 : tail + 1'b1;
                  fill_next = fill + 1'b1;
                end
                if (occ != '0) begin
                  occ_next = occ - 1'b1;
                end
              end
            end
          end
          MODE_CLEAR: begin
            head_next  = '0;
            tail_next  = '0;
            fill_next  = '0;
            fresh_next = '0;
            occ_next   = '0;
          end
        endcase
      end

      S_READ2: begin
        // The freed index is consumed even when its slot turns out to be occupied.
        head_next      = (head == IW'(SLOT_COUNT - 1)) ? '0 : head + 1'b1;
        fill_next      = fill - 1'b1;
        res_index_next = SLOT_IDX_W'(add_idx);
        res_handle_next = '0;
        if (slot_full) begin
          res_err_next = ERR_OCCUPIED;
        end else begin
          slot_we      = 1'b1;
          slot_waddr   = add_idx;
          slot_wdata   = member_r;
          res_err_next = ERR_OK;
          if (occ < CW'(SLOT_COUNT)) begin
            occ_next = occ + 1'b1;
          end
        end
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_index_next  = res_index;
          out_handle_next = res_handle;
          out_count_next  = COUNT_W'(occ);
          out_err_next    = res_err;
          state_next      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      fresh     <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      fresh     <= fresh_next;
      occ       <= occ_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_next;
    sidx_r     <= sidx_next;
    member_r   <= member_next;
    add_idx    <= add_idx_next;
    res_index  <= res_index_next;
    res_handle <= res_handle_next;
    res_err    <= res_err_next;
    out_index  <= out_index_next;
    out_handle <= out_handle_next;
    out_count  <= out_count_next;
    out_err    <= out_err_next;
  end

  // Live slots and queued indices are disjoint sets of issued indices.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(occ) + (CW + 1)'(fill) <= (CW + 1)'(fresh))
    else $error("live plus queued indices exceed issued indices");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_READ1)
    else $error("accepted word did not start its memory read");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_OUT)
    else $error("response word raised outside the output step");

endmodule

`default_nettype wire

>>> rtl/core/stq_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module stq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_slot_table_with_free_index_queue.sv
// Self-checking testbench for the slot table with its queue of freed indices.
module tb_slot_table_with_free_index_queue;
  import stq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 900;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] index;
    logic [HANDLE_W-1:0]   handle;
    logic [COUNT_W-1:0]    live;
    logic [ERR_W-1:0]      err;
  } reply_t;

  logic clk;
  logic rst;

  stq_req_if req_ch ();
  stq_rsp_if rsp_ch ();

  slot_table_with_free_index_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow of the table state, advanced as each request word is accepted.
  logic [HANDLE_W-1:0]   shadow_slots [SLOT_COUNT_DEF];
  logic [SLOT_IDX_W-1:0] shadow_freed [$];
  int unsigned           shadow_issued;
  int unsigned           shadow_live;

  reply_t due_replies [$];

  int  mismatches;
  int  printed;
  int  cycle_count;
  int  hold_request;
  bit  no_idle;
  bit  valid_held;
  int  ops_by_mode [4];
  int  replies_by_err [4];
  int  peak_live;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic reply_t apply_table_op(logic [MODE_W-1:0] op,
                                            logic [SLOT_IDX_W-1:0] sidx,
                                            logic [HANDLE_W-1:0] hnd);
    reply_t r;
    logic [SLOT_IDX_W-1:0] idx;
    r.index  = sidx;
    r.handle = '0;
    r.err    = ERR_OK;
    case (op)
      MODE_ADD: begin
        r.index = '0;
        if (shadow_freed.size() > 0) begin
          idx = shadow_freed.pop_front();
          r.index = idx;
          // A reused slot that is still occupied keeps its handle; the index is consumed.
          if (shadow_slots[idx] != '0) begin
            r.err = ERR_OCCUPIED;
          end else begin
            shadow_slots[idx] = hnd;
            if (shadow_live < SLOT_COUNT_DEF) shadow_live++;
          end
        end else if (shadow_issued < SLOT_COUNT_DEF) begin
          idx = SLOT_IDX_W'(shadow_issued);
          r.index = idx;
          shadow_issued++;
          shadow_slots[idx] = hnd;
          if (shadow_live < SLOT_COUNT_DEF) shadow_live++;
        end else begin
          r.err = ERR_FULL;
        end
      end
      MODE_REMOVE, MODE_GET: begin
        if (sidx >= shadow_issued) begin
          r.err = ERR_RANGE;
        end else begin
          r.handle = shadow_slots[sidx];
          if (op == MODE_REMOVE && r.handle != '0) begin
            shadow_slots[sidx] = '0;
            if (shadow_freed.size() < SLOT_COUNT_DEF) shadow_freed = {shadow_freed, sidx};
            if (shadow_live > 0) shadow_live--;
          end
        end
      end
      default: begin
        shadow_issued = 0;
        shadow_live   = 0;
        shadow_freed.delete();
      end
    endcase
    r.live = COUNT_W'(shadow_live);
    return r;
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] op, input logic [SLOT_IDX_W-1:0] sidx,
                           input logic [HANDLE_W-1:0] hnd);
    reply_t want;
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= op;
    req_ch.slot_index    <= sidx;
    req_ch.member_handle <= hnd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = apply_table_op(op, sidx, hnd);
    due_replies = {due_replies, want};
    ops_by_mode[op]++;
    replies_by_err[want.err]++;
    if (shadow_live > peak_live) peak_live = shadow_live;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_held = 1'b1;
    end
  endtask

  // Lowers valid if the last send left it up; called before the sender stops offering.
  task automatic idle_sender();
    if (valid_held) begin
      req_ch.valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_sender();
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [HANDLE_W-1:0] want,
                              input logic [HANDLE_W-1:0] got);
    mismatches++;
    if (printed < PRINT_CAP) begin
      printed++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_replies.size() == 0) begin
        mismatches++;
        if (printed < PRINT_CAP) begin
          printed++;
          $display("%0t: response word with nothing expected, index 0x%0h handle 0x%0h",
                   $time, rsp_ch.result_index, rsp_ch.result_handle);
        end
      end else begin
        want = due_replies.pop_front();
        if (rsp_ch.result_index !== want.index)
          report_field("result_index", want.index, rsp_ch.result_index);
        if (rsp_ch.result_handle !== want.handle)
          report_field("result_handle", want.handle, rsp_ch.result_handle);
        if (rsp_ch.live_count !== want.live)
          report_field("live_count", want.live, rsp_ch.live_count);
        if (rsp_ch.error_code !== want.err)
          report_field("error_code", want.err, rsp_ch.error_code);
      end
    end
  end

  // Response side: random stalls, plus long holds requested by a test.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, due_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Edge cases on a nearly empty table. A reused slot that is still occupied
  // cannot arise from the ports: freed slots are only refilled through the queue.
  task automatic test_basic_ops();
    send_word(MODE_GET, '0, '0);                // nothing issued yet
    send_word(MODE_REMOVE, '1, '1);             // out of range at the top index
    send_word(MODE_ADD, '0, '1);                // fresh index 0
    send_word(MODE_ADD, '1, '0);                // zero handle still counts as live
    send_word(MODE_ADD, 10'd5, 32'h0000_0001);  // fresh index 2
    send_word(MODE_GET, 10'd0, '0);
    send_word(MODE_GET, 10'd1, '0);             // zero handle reads as empty
    send_word(MODE_REMOVE, 10'd1, '0);          // empty slot, nothing changes
    send_word(MODE_REMOVE, 10'd0, '0);          // frees index 0
    send_word(MODE_REMOVE, 10'd0, '0);          // now empty
    send_word(MODE_REMOVE, 10'd2, '0);          // frees index 2
    send_word(MODE_ADD, '0, 32'h8000_0000);     // reuses oldest freed index
    send_word(MODE_ADD, '0, 32'h7FFF_FFFF);     // reuses next freed index
    send_word(MODE_ADD, '0, 32'hA5A5_5A5A);     // queue empty, fresh index 3
    send_word(MODE_GET, 10'd4, '0);             // one past the issued range
    send_word(MODE_CLEAR, 10'd3, '1);
    send_word(MODE_GET, 10'd0, '0);             // cleared, out of range again
    send_word(MODE_ADD, '0, 32'h1234_5678);
    send_word(MODE_GET, 10'd0, '0);
    wait_drained();
  endtask

  // Issue every index, then hit the full condition and recycle at the top.
  task automatic test_fill_to_full();
    send_word(MODE_CLEAR, '0, '0);
    no_idle = 1'b1;
    for (int i = 0; i < SLOT_COUNT_DEF; i++)
      send_word(MODE_ADD, '0, ($urandom_range(0, 15) == 0) ? '1 : ($urandom() | 32'h1));
    send_word(MODE_ADD, '0, 32'hDEAD_BEEF);     // table full
    no_idle = 1'b0;
    send_word(MODE_GET, '1, '0);
    send_word(MODE_REMOVE, '1, '0);
    send_word(MODE_REMOVE, 10'd512, '0);
    send_word(MODE_ADD, '0, 32'h0000_00FF);     // takes 1023 back
    send_word(MODE_ADD, '0, 32'hFF00_0000);     // takes 512 back
    send_word(MODE_ADD, '0, 32'h0F0F_0F0F);     // full again
    send_word(MODE_GET, '1, '0);
    send_word(MODE_CLEAR, '1, '0);
    wait_drained();
  endtask

  // Hold the response side while requests keep coming, so the input stalls.
  task automatic test_output_stall();
    hold_request = 60;
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++)
      send_word((i % 3 == 2) ? MODE_GET : MODE_ADD, 10'(i / 3), $urandom());
    no_idle = 1'b0;
    wait_drained();
    send_word(MODE_REMOVE, 10'd1, '0);
    send_word(MODE_ADD, '0, $urandom());
    wait_drained();
  endtask

  task automatic test_random_mix();
    int r;
    logic [MODE_W-1:0]     op;
    logic [SLOT_IDX_W-1:0] sidx;
    logic [HANDLE_W-1:0]   hnd;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n % 200) >= 150);
      r = $urandom_range(0, 99);
      if (r < 40)      op = MODE_ADD;
      else if (r < 68) op = MODE_REMOVE;
      else if (r < 99) op = MODE_GET;
      else             op = MODE_CLEAR;
      if (shadow_issued > 0 && $urandom_range(0, 9) < 8)
        sidx = SLOT_IDX_W'($urandom_range(0, shadow_issued - 1));
      else
        sidx = SLOT_IDX_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
      r = $urandom_range(0, 99);
      if (r < 8)       hnd = '0;
      else if (r < 12) hnd = '1;
      else             hnd = $urandom();
      send_word(op, sidx, hnd);
      if (n % 120 == 119) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin : run_tests
    int settle;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ADD;
    req_ch.slot_index = '0;
    req_ch.member_handle = '0;
    mismatches = 0;
    printed = 0;
    cycle_count = 0;
    hold_request = 0;
    no_idle = 1'b0;
    valid_held = 1'b0;
    peak_live = 0;
    shadow_issued = 0;
    shadow_live = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_fill_to_full();
    test_output_stall();
    test_random_mix();

    idle_sender();
    settle = 0;
    while (due_replies.size() != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    if (due_replies.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, due_replies.size());
    end

    $display("Ran %0d add, %0d remove, %0d get, %0d clear; peak live count %0d",
             ops_by_mode[MODE_ADD], ops_by_mode[MODE_REMOVE], ops_by_mode[MODE_GET],
             ops_by_mode[MODE_CLEAR], peak_live);
    $display("Replies by status: ok %0d, occupied %0d, range %0d, full %0d",
             replies_by_err[ERR_OK], replies_by_err[ERR_OCCUPIED],
             replies_by_err[ERR_RANGE], replies_by_err[ERR_FULL]);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
